@@ hw/rtl/nrhw_pkg.sv @@
// ----------------------------------------------------------------------------
// nrhw_pkg
// Shared types, codes and constants of the nested record header walker.
// ----------------------------------------------------------------------------
package nrhw_pkg;

   localparam int DEFAULT_MAX_DEPTH = 16;

   localparam logic [3:0]  VER_CONTAINER         = 4'hF;
   localparam logic [15:0] TYPE_ATOM_EXCEPTION   = 16'h0428;
   localparam logic [15:0] TYPE_FORCED_CONTAINER = 16'h138B;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_STREAM_OK = 3'd1,
      KIND_TRUNCATED = 3'd2,
      KIND_TOO_LONG  = 3'd3,
      KIND_TOO_DEEP  = 3'd4
   } result_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
      logic       stream_end;
   } req_word_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [3:0]      nesting_depth;
      logic [3:0]      rec_version;
      logic [11:0]     rec_instance;
      logic [15:0]     rec_kind;
      logic [31:0]     rec_length;
      logic [31:0]     payload_offset;
      logic            is_container;
      logic            last_in_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_pair_type;

   function automatic rsp_word_type status_word(result_kind_type kind);
      rsp_word_type w;
      w             = '0;
      w.result_kind = kind;
      return w;
   endfunction

endpackage

@@ hw/rtl/nrhw_stream_if.sv @@
// ----------------------------------------------------------------------------
// nrhw_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface nrhw_stream_if #(
   parameter type word_type = logic [7:0]
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

@@ hw/rtl/nrhw_in_reg.sv @@
// ----------------------------------------------------------------------------
// nrhw_in_reg
// Input register: holds one accepted request word until the core takes it.
// ----------------------------------------------------------------------------
module nrhw_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   nrhw_stream_if.sink           req_ch,
   input  logic                  take,
   output logic                  word_vld,
   output nrhw_pkg::req_word_type word
);

   logic                  vld_ff;
   logic                  vld_in;
   logic                  load;
   nrhw_pkg::req_word_type word_ff;

   assign req_ch.ready = !vld_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b0;
      end
      if (load) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_ch.word;
      end
   end

   assign word_vld = vld_ff;
   assign word     = word_ff;

endmodule

@@ hw/rtl/nrhw_core.sv @@
// ----------------------------------------------------------------------------
// nrhw_core
// Header gathering, payload skip, end-offset stack and status generation.
// ----------------------------------------------------------------------------
module nrhw_core #(
   parameter int MAX_DEPTH = nrhw_pkg::DEFAULT_MAX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   word_vld,
   input  nrhw_pkg::req_word_type word,
   input  logic                   room,
   output logic                   take,
   output nrhw_pkg::rsp_pair_type pair
);

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [55:0]   hdr_ff, hdr_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          pay_ff, pay_in;
   logic [31:0]   left_ff, left_in;
   logic [31:0]   pos_ff, pos_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          fail_ff, fail_in;
   logic [31:0]   stack_ff [MAX_DEPTH];

   logic [LW-1:0]        lvl_eff;
   logic [SW-1:0]        push_idx;
   logic [31:0]          pos_nx;
   logic [63:0]          hdr_full;
   logic [3:0]           h_ver;
   logic [11:0]          h_inst;
   logic [15:0]          h_kind;
   logic [31:0]          h_len;
   logic                 h_cont;
   logic [32:0]          end_sum;
   logic [MAX_DEPTH-1:0] ent_eq;
   logic [MAX_DEPTH-1:0] ent_gt;

   logic                      push;
   logic                      rec_end;
   logic                      hdr_hit;
   logic                      st_hit;
   nrhw_pkg::result_kind_type st_kind;
   logic                      found;
   logic [SW-1:0]             top_idx;
   nrhw_pkg::rsp_word_type    hdr_word;
   nrhw_pkg::rsp_word_type    st_word;

   assign take     = word_vld && room;
   assign lvl_eff  = word.stream_start ? '0 : lvl_ff;
   assign push_idx = lvl_eff[SW-1:0];
   assign pos_nx   = (word.stream_start ? 32'd0 : pos_ff) + 32'd1;
   assign hdr_full = {word.data_byte, hdr_ff};
   assign h_ver    = hdr_full[3:0];
   assign h_inst   = hdr_full[15:4];
   assign h_kind   = hdr_full[31:16];
   assign h_len    = hdr_full[63:32];
   assign h_cont   = (h_ver == nrhw_pkg::VER_CONTAINER
                      && h_kind != nrhw_pkg::TYPE_ATOM_EXCEPTION)
                     || h_kind == nrhw_pkg::TYPE_FORCED_CONTAINER;
   assign end_sum  = {1'b0, pos_nx} + {1'b0, h_len};

   for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cmp
      assign ent_eq[g] = (push && push_idx == SW'(g)) ? (h_len == 32'd0)
                                                      : (stack_ff[g] == pos_nx);
      assign ent_gt[g] = !(push && push_idx == SW'(g)) && (pos_nx > stack_ff[g]);
   end

   always_comb begin
      hdr_in  = hdr_ff;
      cnt_in  = cnt_ff;
      pay_in  = pay_ff;
      left_in = left_ff;
      pos_in  = pos_ff;
      lvl_in  = lvl_ff;
      fail_in = fail_ff;
      push    = 1'b0;
      rec_end = 1'b0;
      hdr_hit = 1'b0;
      st_hit  = 1'b0;
      st_kind = nrhw_pkg::KIND_STREAM_OK;
      found   = 1'b0;
      top_idx = '0;
      if (take) begin
         if (word.stream_start) begin
            hdr_in  = '0;
            cnt_in  = '0;
            pay_in  = 1'b0;
            left_in = '0;
            pos_in  = '0;
            lvl_in  = '0;
            fail_in = 1'b0;
         end
         if (!fail_in) begin
            pos_in = pos_nx;
            if (pay_in) begin
               left_in = left_in - 32'd1;
               if (left_in == 32'd0) begin
                  pay_in  = 1'b0;
                  rec_end = 1'b1;
               end
            end else if (cnt_in != 3'd7) begin
               hdr_in[{cnt_in, 3'b000} +: 8] = word.data_byte;
               cnt_in                        = cnt_in + 3'd1;
            end else begin
               hdr_in  = '0;
               cnt_in  = '0;
               hdr_hit = 1'b1;
               if (h_cont) begin
                  if (lvl_eff >= LW'(MAX_DEPTH)) begin
                     st_hit  = 1'b1;
                     st_kind = nrhw_pkg::KIND_TOO_DEEP;
                     fail_in = 1'b1;
                  end else if (end_sum[32]) begin
                     st_hit  = 1'b1;
                     st_kind = nrhw_pkg::KIND_TOO_LONG;
                     fail_in = 1'b1;
                  end else begin
                     push    = 1'b1;
                     lvl_in  = lvl_eff + LW'(1);
                     rec_end = 1'b1;
                  end
               end else if (h_len == 32'd0) begin
                  rec_end = 1'b1;
               end else begin
                  pay_in  = 1'b1;
                  left_in = h_len;
               end
            end

            if (rec_end) begin
               for (int i = 0; i < MAX_DEPTH; i++) begin
                  if (LW'(i) < lvl_in && !ent_eq[i]) begin
                     found   = 1'b1;
                     top_idx = SW'(i);
                  end
               end
               if (!found) begin
                  lvl_in = '0;
               end else begin
                  lvl_in = LW'(top_idx) + LW'(1);
                  if (ent_gt[top_idx]) begin
                     st_hit  = 1'b1;
                     st_kind = nrhw_pkg::KIND_TOO_LONG;
                     fail_in = 1'b1;
                  end
               end
            end

            if (word.stream_end && !fail_in) begin
               st_hit  = 1'b1;
               st_kind = (cnt_in == 3'd0 && !pay_in && lvl_in == '0)
                         ? nrhw_pkg::KIND_STREAM_OK : nrhw_pkg::KIND_TRUNCATED;
               fail_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      hdr_word                = '0;
      hdr_word.result_kind    = nrhw_pkg::KIND_HEADER;
      hdr_word.nesting_depth  = 4'(lvl_eff);
      hdr_word.rec_version    = h_ver;
      hdr_word.rec_instance   = h_inst;
      hdr_word.rec_kind       = h_kind;
      hdr_word.rec_length     = h_len;
      hdr_word.payload_offset = pos_nx;
      hdr_word.is_container   = h_cont;
      st_word                 = nrhw_pkg::status_word(st_kind);
      st_word.last_in_run     = 1'b1;

      pair.count  = 2'({1'b0, hdr_hit} + {1'b0, st_hit});
      pair.first  = hdr_hit ? hdr_word : st_word;
      pair.second = st_word;
      pair.first.last_in_run = !(hdr_hit && st_hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pay_ff  <= 1'b0;
         left_ff <= '0;
         pos_ff  <= '0;
         lvl_ff  <= '0;
         fail_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pay_ff  <= pay_in;
         left_ff <= left_in;
         pos_ff  <= pos_in;
         lvl_ff  <= lvl_in;
         fail_ff <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[push_idx] <= end_sum[31:0];
      end
   end

   a_lvl_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(MAX_DEPTH))
      else $error("nesting level beyond stack depth");

   a_skip_no_hdr: assert property (@(posedge clock) disable iff (reset)
      pay_ff |-> (cnt_ff == 3'd0 && left_ff != 32'd0))
      else $error("payload skip overlaps header gathering");

   a_pair_fails: assert property (@(posedge clock) disable iff (reset)
      take && pair.count == 2'd2 |=> fail_ff)
      else $error("two results without stopping the stream");

   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      take && fail_ff && !word.stream_start |-> pair.count == 2'd0)
      else $error("result from a stopped stream");

endmodule

@@ hw/rtl/nrhw_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// nrhw_rsp_fifo
// Result queue: takes up to two words per cycle, hands out one per handshake.
// ----------------------------------------------------------------------------
module nrhw_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  nrhw_pkg::rsp_pair_type pair,
   output logic                   room,
   nrhw_stream_if.source          rsp_ch
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   nrhw_pkg::rsp_word_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop;

   assign pop          = rsp_ch.valid && rsp_ch.ready;
   assign room         = cnt_ff <= CW'(DEPTH - 2);
   assign rsp_ch.valid = cnt_ff != '0;
   assign rsp_ch.word  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + PW'(pair.count);
      rd_in  = rd_ff + PW'(pop);
      cnt_in = cnt_ff + CW'(pair.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) begin
         mem_ff[wr_ff] <= pair.first;
      end
      if (pair.count == 2'd2) begin
         mem_ff[wr_ff + PW'(1)] <= pair.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pair.count != 2'd0 |-> room)
      else $error("result queue written without room");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("result queue count out of range");

endmodule

@@ hw/rtl/nested_record_header_walker.sv @@
// ----------------------------------------------------------------------------
// nested_record_header_walker
// Walks a byte stream of nested binary records and reports every header.
//
// req_ch takes one stream byte per word, with start and end marks. rsp_ch
// gives header words (depth, version, instance, type, length, payload
// offset, container flag) and one status word per stream: ok, truncated,
// too long or too deep. last_in_run marks the final word caused by a byte.
// A byte yields zero, one or two words.
// Throughput: one byte per cycle while each byte yields at most one word;
// and rsp_ch does not stall; a byte that yields two words hands them out
// one per handshake. The end offsets of open containers are compared
// against the position all at once, so any number of containers close
// on the same byte. A word passes through the input register and then
// the result queue before it is valid on rsp_ch.
// Reset clears the walker; the first stream then starts at position zero.
// When rsp_ch stalls, the four-entry result queue fills and req_ch drops
// ready; nothing is lost. After a status word the walker ignores bytes
// until the next start mark.
// ----------------------------------------------------------------------------
module nested_record_header_walker #(
   parameter int MAX_DEPTH = nrhw_pkg::DEFAULT_MAX_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   nrhw_stream_if.sink   req_ch,
   nrhw_stream_if.source rsp_ch
);

   logic                   word_vld;
   nrhw_pkg::req_word_type word;
   logic                   take;
   logic                   room;
   nrhw_pkg::rsp_pair_type pair;

   nrhw_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .take     (take),
      .word_vld (word_vld),
      .word     (word)
   );

   nrhw_core #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .word_vld (word_vld),
      .word     (word),
      .room     (room),
      .take     (take),
      .pair     (pair)
   );

   nrhw_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .pair   (pair),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nested record header walker. Byte streams of
// nested records (well-formed, damaged, deep and pure noise) go in with
// random gaps. A bit-accurate walker model in the bench predicts every
// header and status word. An output monitor compares each word with the
// oldest prediction while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_DEPTH     = nrhw_pkg::DEFAULT_MAX_DEPTH;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_BYTES  = 1250;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [7:0] byte_q_type [$];

   logic clock;
   logic reset;

   nrhw_stream_if #(.word_type(nrhw_pkg::req_word_type)) req_ch ();
   nrhw_stream_if #(.word_type(nrhw_pkg::rsp_word_type)) rsp_ch ();

   nested_record_header_walker #(.MAX_DEPTH(MAX_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // walker model state
   logic [63:0] hdr_shift;
   int unsigned hdr_count;
   bit          skipping;
   logic [31:0] skip_left;
   logic [31:0] position;
   logic [31:0] open_end [MAX_DEPTH];
   int unsigned level;
   bit          stopped;

   nrhw_pkg::rsp_word_type expected_words [$];
   nrhw_pkg::rsp_word_type got_word, want_word;
   int           bytes_walked;
   int           mismatches;
   int           cycles;
   int           stall_left;
   bit           idle_enable;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic clear_walker();
      hdr_shift = '0;
      hdr_count = 0;
      skipping  = 1'b0;
      skip_left = '0;
      position  = '0;
      level     = 0;
      stopped   = 1'b0;
   endtask

   task automatic advance_walker(input nrhw_pkg::req_word_type w);
      nrhw_pkg::rsp_word_type run [$];
      nrhw_pkg::rsp_word_type hw;
      nrhw_pkg::rsp_word_type sw;
      logic [32:0]  end_pos;
      bit           rec_done;
      bit           cont;
      rec_done = 1'b0;
      sw       = '0;
      if (w.stream_start) clear_walker();
      if (stopped) return;
      position = position + 32'd1;
      if (skipping) begin
         skip_left = skip_left - 32'd1;
         if (skip_left == 32'd0) begin
            skipping = 1'b0;
            rec_done = 1'b1;
         end
      end else begin
         hdr_shift[8*hdr_count +: 8] = w.data_byte;
         hdr_count++;
         if (hdr_count == 8) begin
            hw                = '0;
            hw.result_kind    = nrhw_pkg::KIND_HEADER;
            hw.nesting_depth  = level[3:0];
            hw.rec_version    = hdr_shift[3:0];
            hw.rec_instance   = hdr_shift[15:4];
            hw.rec_kind       = hdr_shift[31:16];
            hw.rec_length     = hdr_shift[63:32];
            hw.payload_offset = position;
            cont = (hw.rec_version == nrhw_pkg::VER_CONTAINER
                    && hw.rec_kind != nrhw_pkg::TYPE_ATOM_EXCEPTION)
                   || hw.rec_kind == nrhw_pkg::TYPE_FORCED_CONTAINER;
            hw.is_container   = cont;
            hdr_shift = '0;
            hdr_count = 0;
            run.push_back(hw);
            if (cont) begin
               end_pos = {1'b0, position} + {1'b0, hw.rec_length};
               if (level >= MAX_DEPTH) begin
                  sw.result_kind = nrhw_pkg::KIND_TOO_DEEP;
                  run.push_back(sw);
                  stopped = 1'b1;
               end else if (end_pos[32]) begin
                  sw.result_kind = nrhw_pkg::KIND_TOO_LONG;
                  run.push_back(sw);
                  stopped = 1'b1;
               end else begin
                  open_end[level] = end_pos[31:0];
                  level++;
                  rec_done = 1'b1;
               end
            end else if (hw.rec_length == 32'd0) begin
               rec_done = 1'b1;
            end else begin
               skipping  = 1'b1;
               skip_left = hw.rec_length;
            end
         end
      end
      if (rec_done && !stopped) begin
         while (level > 0) begin
            if (position > open_end[level-1]) begin
               sw.result_kind = nrhw_pkg::KIND_TOO_LONG;
               run.push_back(sw);
               stopped = 1'b1;
               break;
            end
            if (position != open_end[level-1]) break;
            level--;
         end
      end
      if (w.stream_end && !stopped) begin
         sw.result_kind = (hdr_count == 0 && !skipping && level == 0) ?
                          nrhw_pkg::KIND_STREAM_OK : nrhw_pkg::KIND_TRUNCATED;
         run.push_back(sw);
         stopped = 1'b1;
      end
      if (run.size() > 0) begin
         hw = run.pop_back();
         hw.last_in_run = 1'b1;
         run.push_back(hw);
         foreach (run[i]) expected_words.push_back(run[i]);
      end
   endtask

   task automatic report_mismatch(input nrhw_pkg::rsp_word_type want,
                                  input nrhw_pkg::rsp_word_type got,
                                  input bit orphan);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         if (orphan)
            $display({"unexpected word: kind=%0d depth=%0d ver=%h inst=%h",
                      " type=%h len=%h off=%h"},
                     got.result_kind, got.nesting_depth, got.rec_version, got.rec_instance,
                     got.rec_kind, got.rec_length, got.payload_offset);
         else begin
            $display({"mismatch expected: kind=%0d depth=%0d ver=%h inst=%h",
                      " type=%h len=%h off=%h c=%b l=%b"},
                     want.result_kind, want.nesting_depth, want.rec_version, want.rec_instance,
                     want.rec_kind, want.rec_length, want.payload_offset, want.is_container,
                     want.last_in_run);
            $display({"         actual:   kind=%0d depth=%0d ver=%h inst=%h",
                      " type=%h len=%h off=%h c=%b l=%b"},
                     got.result_kind, got.nesting_depth, got.rec_version, got.rec_instance,
                     got.rec_kind, got.rec_length, got.payload_offset, got.is_container,
                     got.last_in_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_word = rsp_ch.word;
         if (expected_words.size() == 0) begin
            report_mismatch('0, got_word, 1'b1);
         end else begin
            want_word = expected_words.pop_front();
            if (got_word.result_kind    !== want_word.result_kind    ||
                got_word.nesting_depth  !== want_word.nesting_depth  ||
                got_word.rec_version    !== want_word.rec_version    ||
                got_word.rec_instance   !== want_word.rec_instance   ||
                got_word.rec_kind       !== want_word.rec_kind       ||
                got_word.rec_length     !== want_word.rec_length     ||
                got_word.payload_offset !== want_word.payload_offset ||
                got_word.is_container   !== want_word.is_container   ||
                got_word.last_in_run    !== want_word.last_in_run)
               report_mismatch(want_word, got_word, 1'b0);
         end
      end
   end

   // output back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idle_enable && $urandom_range(0, 5) == 0) stall_left = gap_len();
      end
   end

   task automatic send_byte(input logic [7:0] data, input bit first, input bit last);
      nrhw_pkg::req_word_type w;
      int           gap;
      w.data_byte    = data;
      w.stream_start = first;
      w.stream_end   = last;
      gap = idle_enable ? gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      do @(posedge clock); while (!req_ch.ready);
      advance_walker(w);
      bytes_walked++;
   endtask

   task automatic send_stream(input byte_q_type q, input bit with_start, input bit with_end);
      foreach (q[i])
         send_byte(q[i], with_start && i == 0, with_end && i == q.size() - 1);
   endtask

   task automatic put_header(ref byte_q_type q, input logic [3:0] ver,
                             input logic [11:0] inst, input logic [15:0] kind,
                             input logic [31:0] len);
      logic [63:0] h;
      h = {len, kind, inst, ver};
      for (int i = 0; i < 8; i++) q.push_back(h[8*i +: 8]);
   endtask

   task automatic build_record(input int depth, input int nest_cap, input bit faults,
                               output byte_q_type q);
      byte_q_type  body;
      byte_q_type  child;
      logic [3:0]  ver;
      logic [11:0] inst;
      logic [15:0] kind;
      logic [31:0] len;
      int          n;
      q    = {};
      body = {};
      inst = 12'($urandom);
      if (depth < nest_cap && $urandom_range(0, 2) != 0) begin
         if ($urandom_range(0, 3) == 0) begin
            ver  = 4'($urandom);
            kind = nrhw_pkg::TYPE_FORCED_CONTAINER;
         end else begin
            ver  = nrhw_pkg::VER_CONTAINER;
            kind = 16'($urandom);
            if (kind == nrhw_pkg::TYPE_ATOM_EXCEPTION) kind = nrhw_pkg::TYPE_FORCED_CONTAINER;
         end
         n = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            build_record(depth + 1, nest_cap, faults, child);
            body = {body, child};
         end
      end else begin
         ver = ($urandom_range(0, 7) == 0) ? nrhw_pkg::VER_CONTAINER
                                           : 4'($urandom_range(0, 14));
         if (ver == nrhw_pkg::VER_CONTAINER) kind = nrhw_pkg::TYPE_ATOM_EXCEPTION;
         else begin
            kind = 16'($urandom);
            if (kind == nrhw_pkg::TYPE_FORCED_CONTAINER) kind = kind ^ 16'h0001;
         end
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      end
      len = 32'(body.size());
      if (faults && $urandom_range(0, 5) == 0) begin
         if (len > 0 && $urandom_range(0, 1) == 0) len = len - 32'($urandom_range(1, len));
         else len = len + 32'($urandom_range(1, 3));
      end
      put_header(q, ver, inst, kind, len);
      q = {q, body};
   endtask

   task automatic build_chain(input int containers, input bit inner_atom,
                              output byte_q_type q);
      byte_q_type wrapped;
      q = {};
      if (inner_atom)
         put_header(q, 4'($urandom_range(0, 14)), 12'($urandom), 16'h0000, 32'd0);
      for (int i = 0; i < containers; i++) begin
         wrapped = {};
         put_header(wrapped, nrhw_pkg::VER_CONTAINER, 12'($urandom),
                    16'($urandom_range(0, 16'h0427)), 32'(q.size()));
         wrapped = {wrapped, q};
         q = wrapped;
      end
   endtask

   task automatic test_after_reset();
      byte_q_type q;
      q = {};
      put_header(q, 4'h3, 12'h5A5, 16'h1234, 32'd0);
      send_stream(q, 1'b0, 1'b1);
   endtask

   task automatic test_field_extremes();
      byte_q_type q;
      q = {};
      put_header(q, 4'h0, 12'h000, 16'h0000, 32'd0);
      put_header(q, 4'hE, 12'hFFF, 16'hFFFF, 32'd0);
      put_header(q, nrhw_pkg::VER_CONTAINER, 12'hFFF, nrhw_pkg::TYPE_ATOM_EXCEPTION, 32'd1);
      q.push_back(8'hFF);
      put_header(q, 4'h0, 12'h800, nrhw_pkg::TYPE_FORCED_CONTAINER, 32'd8);
      put_header(q, 4'h1, 12'h001, 16'h8000, 32'd0);
      put_header(q, nrhw_pkg::VER_CONTAINER, 12'h0AA, 16'h0001, 32'd0);
      send_stream(q, 1'b1, 1'b1);
   endtask

   task automatic test_truncation();
      byte_q_type q;
      send_byte(8'hA5, 1'b1, 1'b1);
      q = {};
      put_header(q, 4'h2, 12'h123, 16'h4567, 32'd0);
      q = q[0:4];
      send_stream(q, 1'b1, 1'b1);
      q = {};
      put_header(q, 4'h2, 12'h123, 16'h4567, 32'd3);
      q.push_back(8'h00);
      send_stream(q, 1'b1, 1'b1);
      q = {};
      put_header(q, nrhw_pkg::VER_CONTAINER, 12'h001, 16'h0002, 32'd16);
      put_header(q, 4'h0, 12'h002, 16'h0003, 32'd0);
      send_stream(q, 1'b1, 1'b1);
   endtask

   task automatic test_overrun();
      byte_q_type q;
      q = {};
      put_header(q, nrhw_pkg::VER_CONTAINER, 12'h010, 16'h0020, 32'd4);
      put_header(q, 4'h0, 12'h011, 16'h0021, 32'd0);
      send_stream(q, 1'b1, 1'b0);
      // stopped: both bytes are dropped, the end mark too
      send_byte(8'h5A, 1'b0, 1'b0);
      send_byte(8'hC3, 1'b0, 1'b1);
      q = {};
      put_header(q, nrhw_pkg::VER_CONTAINER, 12'h020, 16'h0030, 32'hFFFF_FFFF);
      send_stream(q, 1'b1, 1'b1);
      q = {};
      put_header(q, 4'h7, 12'h030, 16'h0040, 32'hFFFF_FFFF);
      q.push_back(8'h11);
      q.push_back(8'h22);
      send_stream(q, 1'b1, 1'b1);
   endtask

   task automatic test_too_deep();
      byte_q_type q;
      build_chain(MAX_DEPTH + 1, 1'b0, q);
      send_stream(q, 1'b1, 1'b1);
      build_chain(MAX_DEPTH, 1'b1, q);
      send_stream(q, 1'b1, 1'b1);
   endtask

   task automatic test_random_streams();
      byte_q_type q;
      byte_q_type rec;
      int      target;
      int      mode;
      int      n;
      target = bytes_walked + RANDOM_BYTES;
      while (bytes_walked < target) begin
         idle_enable = ($urandom_range(0, 4) != 0);
         mode = $urandom_range(0, 99);
         q = {};
         if (mode < 80) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               build_record(0, $urandom_range(0, 3), mode >= 68, rec);
               q = {q, rec};
            end
            if (mode >= 74 && q.size() > 1 && $urandom_range(0, 1) == 0)
               q = q[0:$urandom_range(0, q.size() - 2)];
            else if (mode >= 74)
               q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            send_stream(q, 1'b1, 1'b1);
         end else if (mode < 85) begin
            build_chain($urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 1),
                        1'($urandom_range(0, 1)), q);
            send_stream(q, 1'b1, 1'b1);
         end else if (mode < 95) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.word  = '0;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      idle_enable  = 1'b1;
      bytes_walked = 0;
      mismatches   = 0;
      cycles       = 0;
      clear_walker();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_field_extremes();
      test_truncation();
      test_overrun();
      test_too_deep();
      test_random_streams();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_words.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_words.size() > 0) mismatches++;

      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/nrhw_pkg.sv
hw/rtl/nrhw_stream_if.sv
hw/rtl/nrhw_in_reg.sv
hw/rtl/nrhw_core.sv
hw/rtl/nrhw_rsp_fifo.sv
hw/rtl/nested_record_header_walker.sv
tb/sv/tb_top.sv
